// ===== rtl/jaw_and_igniter_sequencer_assert.svh =====
// Assertion macros for the jaw and igniter sequencer.
// Included by the top level; needs no package.
`ifndef JAW_AND_IGNITER_SEQUENCER_ASSERT_SVH
`define JAW_AND_IGNITER_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define JAIS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked outside reset
`define JAIS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define JAIS_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define JAIS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/jais_pkg.sv =====
// Shared types and constants for the jaw and igniter sequencer.
// No dependencies.
package jais_pkg;

    // Register field widths
    localparam int LIMIT_W = 7;
    localparam int KICK_W  = 16;
    localparam int DUTY_W  = 8;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default parameter values
    localparam int KICK_TIMER_BITS_DEF = 16;
    localparam int INTEGRATOR_BITS_DEF = 8;

    // Register reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 7'd32;
    localparam logic [KICK_W-1:0]  KICK_RST      = 16'd250;
    localparam logic [DUTY_W-1:0]  JAW_HOLD_RST  = 8'hcc;
    localparam logic [DUTY_W-1:0]  FUEL_HOLD_RST = 8'hff;
    localparam logic [DUTY_W-1:0]  DUTY_FULL     = 8'hff;
    localparam logic [DUTY_W-1:0]  DUTY_OFF      = 8'h00;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_LIMIT = 2'd0,
        REG_KICK_TICKS     = 2'd1,
        REG_JAW_HOLD_DUTY  = 2'd2,
        REG_FUEL_HOLD_DUTY = 2'd3
    } t_reg_idx;

    // External phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_REL_KICK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_REL_HOLD  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_JAW_KICK  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_IGNITE    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FUEL_KICK = 3'd5;
    localparam logic [PHASE_W-1:0] PH_BURN      = 3'd6;

    // Sequencer state, one-hot
    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_REL_KICK  = 7'b0000010,
        ST_REL_HOLD  = 7'b0000100,
        ST_JAW_KICK  = 7'b0001000,
        ST_IGNITE    = 7'b0010000,
        ST_FUEL_KICK = 7'b0100000,
        ST_BURN      = 7'b1000000
    } t_state;

    // One result beat
    typedef struct packed {
        logic [DUTY_W-1:0]  jaw_duty;
        logic [DUTY_W-1:0]  fuel_duty;
        logic               igniter_on;
        logic [PHASE_W-1:0] phase;
    } t_result;

endpackage

// ===== rtl/jais_debounce.sv =====
// Saturating up/down integrator with hysteresis for one active-low button.
// Depends on jais_pkg.
module jais_debounce import jais_pkg::*; #(
    parameter int INTEGRATOR_BITS = INTEGRATOR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_pin,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_pressed_q,
    output logic               o_pressed_d
);

    localparam int LW  = (INTEGRATOR_BITS > LIMIT_W) ? INTEGRATOR_BITS : LIMIT_W;
    localparam int CAP = (1 << (INTEGRATOR_BITS - 1)) - 1;
    localparam logic signed [INTEGRATOR_BITS-1:0] ONE = INTEGRATOR_BITS'(1);

    logic signed [INTEGRATOR_BITS-1:0] r_acc, n_acc;
    logic                              r_pressed, n_pressed;
    logic [LW-1:0]                     lim_u;
    logic signed [INTEGRATOR_BITS-1:0] lim, neg_lim;

    // Effective limit: zero acts as one, clamp to the integrator range
    always_comb begin
        lim_u = LW'(i_limit);
        if (lim_u == '0) begin
            lim_u = LW'(1);
        end else if (lim_u > LW'(CAP)) begin
            lim_u = LW'(CAP);
        end
        lim     = signed'(INTEGRATOR_BITS'(lim_u));
        neg_lim = -lim;
    end

    // Saturate into the band, step toward the pin level, then hysteresis
    always_comb begin
        n_acc     = r_acc;
        n_pressed = r_pressed;
        if (n_acc > lim)     n_acc = lim;
        if (n_acc < neg_lim) n_acc = neg_lim;
        if (!i_pin) begin
            if (n_acc > neg_lim) n_acc = n_acc - ONE;
        end else begin
            if (n_acc < lim) n_acc = n_acc + ONE;
        end
        if (n_acc == neg_lim) n_pressed = 1'b1;
        if (n_acc == lim)     n_pressed = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_pressed <= 1'b0;
        end else if (i_en) begin
            r_acc     <= n_acc;
            r_pressed <= n_pressed;
        end
    end

    assign o_pressed_q = r_pressed;
    assign o_pressed_d = n_pressed;

endmodule

// ===== rtl/jais_seq.sv =====
// Phase state machine with kick countdown and drive decode.
// Depends on jais_pkg.
module jais_seq import jais_pkg::*; #(
    parameter int KICK_TIMER_BITS = KICK_TIMER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_rel_q,
    input  logic              i_rel_d,
    input  logic              i_fire_q,
    input  logic              i_fire_d,
    input  logic [KICK_W-1:0] i_kick_ticks,
    input  logic [DUTY_W-1:0] i_jaw_hold,
    input  logic [DUTY_W-1:0] i_fuel_hold,
    output t_result           o_result
);

    localparam int KB = KICK_TIMER_BITS;
    localparam int KW = (KB > KICK_W) ? KB : KICK_W;
    localparam logic [KW-1:0] TMAX = KW'((64'd1 << KB) - 64'd1);

    t_state        r_state, n_state;
    logic [KB-1:0] r_count, n_count;
    logic [KW-1:0] k_sat;
    logic          kick_zero;
    logic          rel_new, fire_new;

    // Kick length saturated to the timer
    always_comb begin
        k_sat = KW'(i_kick_ticks);
        if (k_sat > TMAX) k_sat = TMAX;
        kick_zero = (k_sat == '0);
    end

    assign rel_new  = i_rel_d  & ~i_rel_q;
    assign fire_new = i_fire_d & ~i_fire_q;

    // Next phase
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_REL_KICK, ST_JAW_KICK, ST_FUEL_KICK: begin
                if (r_count == '0) begin
                    if (r_state == ST_REL_KICK)      n_state = ST_REL_HOLD;
                    else if (r_state == ST_JAW_KICK) n_state = ST_IGNITE;
                    else                             n_state = ST_BURN;
                end else begin
                    n_count = r_count - KB'(1);
                end
            end
            ST_REL_HOLD: begin
                if (!i_rel_d) n_state = ST_IDLE;
            end
            ST_IGNITE: begin
                if (i_fire_d) begin
                    n_state = kick_zero ? ST_BURN : ST_FUEL_KICK;
                    n_count = kick_zero ? '0 : KB'(k_sat - KW'(1));
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_BURN: begin
                if (!i_fire_d) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
                if (rel_new) begin
                    n_state = kick_zero ? ST_REL_HOLD : ST_REL_KICK;
                    n_count = kick_zero ? '0 : KB'(k_sat - KW'(1));
                end else if (fire_new) begin
                    n_state = kick_zero ? ST_IGNITE : ST_JAW_KICK;
                    n_count = kick_zero ? '0 : KB'(k_sat - KW'(1));
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else if (i_en) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Drive decode from the updated phase
    always_comb begin
        o_result = '{jaw_duty: DUTY_OFF, fuel_duty: DUTY_OFF, igniter_on: 1'b0,
                     phase: PH_IDLE};
        unique case (n_state)
            ST_REL_KICK: begin
                o_result.jaw_duty = DUTY_FULL;
                o_result.phase    = PH_REL_KICK;
            end
            ST_REL_HOLD: begin
                o_result.jaw_duty = i_jaw_hold;
                o_result.phase    = PH_REL_HOLD;
            end
            ST_JAW_KICK: begin
                o_result.jaw_duty = DUTY_FULL;
                o_result.phase    = PH_JAW_KICK;
            end
            ST_IGNITE: begin
                o_result.jaw_duty   = i_jaw_hold;
                o_result.igniter_on = 1'b1;
                o_result.phase      = PH_IGNITE;
            end
            ST_FUEL_KICK: begin
                o_result.jaw_duty   = i_jaw_hold;
                o_result.fuel_duty  = DUTY_FULL;
                o_result.igniter_on = 1'b1;
                o_result.phase      = PH_FUEL_KICK;
            end
            ST_BURN: begin
                o_result.jaw_duty   = i_jaw_hold;
                o_result.fuel_duty  = i_fuel_hold;
                o_result.igniter_on = 1'b1;
                o_result.phase      = PH_BURN;
            end
            default: begin
                o_result.phase = PH_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/jais_outq.sv =====
// Two-entry result queue: two-slot ring buffer with read and write pointers.
// Depends on jais_pkg.
module jais_outq import jais_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result    r_buf [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       do_pop;

    assign do_pop  = i_pop & (r_cnt != 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop)      n_cnt = r_cnt + 2'd1;
        else if (!i_push && do_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop) r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= n_cnt;
        end
    end

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wr_ptr] <= i_data;
    end

endmodule

// ===== rtl/jaw_and_igniter_sequencer.sv =====
// Jaw and igniter sequencer: debounces two buttons and steps the actuator phases.
// Depends on jais_pkg, jais_debounce, jais_seq, jais_outq and the assertion header.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one millisecond tick per beat with
//   the raw active-low release and fire pin levels. Output channel
//   (o_valid/i_ready) returns exactly one result beat per tick: jaw and fuel
//   duties, igniter drive and phase code.
//   Each result is queued when its tick is accepted, behind any results waiting.
//   Throughput: one tick per cycle while o_ready is high; the debounce and phase
//   updates are a single pass of logic between the state registers.
//   A two-entry result queue lets a tick be accepted while one result waits;
//   o_ready drops only when both entries are held by a stalled receiver.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at once;
//   write only while no result is outstanding.
//   Reset (synchronous, i_rst_n low): integrators zero, buttons released,
//   phase idle, queue empty, registers back to their defaults.
`include "jaw_and_igniter_sequencer_assert.svh"

module jaw_and_igniter_sequencer import jais_pkg::*; #(
    parameter int KICK_TIMER_BITS = KICK_TIMER_BITS_DEF,
    parameter int INTEGRATOR_BITS = INTEGRATOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tick channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_release_pin,
    input  logic                  i_fire_pin,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DUTY_W-1:0]     o_jaw_duty,
    output logic [DUTY_W-1:0]     o_fuel_duty,
    output logic                  o_igniter_on,
    output logic [PHASE_W-1:0]    o_phase,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [LIMIT_W-1:0] r_limit;
    logic [KICK_W-1:0]  r_kick;
    logic [DUTY_W-1:0]  r_jaw_hold;
    logic [DUTY_W-1:0]  r_fuel_hold;

    logic    tick;
    logic    rel_q, rel_d, fire_q, fire_d;
    logic    q_space;
    t_result seq_res, out_res;

    assign o_ready = q_space;
    assign tick    = i_valid & q_space;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RST;
            r_kick      <= KICK_RST;
            r_jaw_hold  <= JAW_HOLD_RST;
            r_fuel_hold <= FUEL_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DEBOUNCE_LIMIT: r_limit     <= i_cfg_data[LIMIT_W-1:0];
                REG_KICK_TICKS:     r_kick      <= i_cfg_data[KICK_W-1:0];
                REG_JAW_HOLD_DUTY:  r_jaw_hold  <= i_cfg_data[DUTY_W-1:0];
                REG_FUEL_HOLD_DUTY: r_fuel_hold <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Button debouncers, both advance on each tick beat
    jais_debounce #(.INTEGRATOR_BITS(INTEGRATOR_BITS)) u_rel_db (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (tick),
        .i_pin       (i_release_pin),
        .i_limit     (r_limit),
        .o_pressed_q (rel_q),
        .o_pressed_d (rel_d)
    );

    jais_debounce #(.INTEGRATOR_BITS(INTEGRATOR_BITS)) u_fire_db (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (tick),
        .i_pin       (i_fire_pin),
        .i_limit     (r_limit),
        .o_pressed_q (fire_q),
        .o_pressed_d (fire_d)
    );

    // Phase sequencer
    jais_seq #(.KICK_TIMER_BITS(KICK_TIMER_BITS)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (tick),
        .i_rel_q      (rel_q),
        .i_rel_d      (rel_d),
        .i_fire_q     (fire_q),
        .i_fire_d     (fire_d),
        .i_kick_ticks (r_kick),
        .i_jaw_hold   (r_jaw_hold),
        .i_fuel_hold  (r_fuel_hold),
        .o_result     (seq_res)
    );

    // Result queue
    jais_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tick),
        .i_data  (seq_res),
        .o_space (q_space),
        .o_valid (o_valid),
        .i_pop   (i_ready),
        .o_data  (out_res)
    );

    assign o_jaw_duty   = out_res.jaw_duty;
    assign o_fuel_duty  = out_res.fuel_duty;
    assign o_igniter_on = out_res.igniter_on;
    assign o_phase      = out_res.phase;

    // Checks
    `JAIS_ASSERT_NEXT(a_tick_gives_beat, i_clk, i_rst_n, tick, o_valid)
    `JAIS_ASSERT_IMPL(a_full_means_valid, i_clk, i_rst_n, !o_ready, o_valid && !$past(i_ready && o_valid))
    `JAIS_ASSERT_IMPL(a_idle_all_off, i_clk, i_rst_n, o_valid && o_phase == PH_IDLE, o_jaw_duty == DUTY_OFF && o_fuel_duty == DUTY_OFF && !o_igniter_on)
    `JAIS_ASSERT_IMPL(a_fuel_needs_igniter, i_clk, i_rst_n, o_valid && o_fuel_duty != DUTY_OFF, o_igniter_on)

endmodule
